### hw/rtl/kect_pkg.sv
package kect_pkg;

    localparam int NumSlotsDef = 32;
    localparam int MaxOut      = 32;
    localparam int LimW        = 6;
    localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

    localparam logic [1:0] OpRecord = 2'd0;
    localparam logic [1:0] OpDump   = 2'd1;
    localparam logic [1:0] OpClear  = 2'd2;

    typedef struct packed {
        logic [1:0]      operation;
        logic [15:0]     in_cluster;
        logic [15:0]     in_attr_or_cmd;
        logic            in_specific;
        logic [63:0]     in_device_address;
        logic [31:0]     in_time_s;
        logic [LimW-1:0] dump_limit;
    } t_in_req;

    typedef struct packed {
        logic [15:0] out_cluster;
        logic [15:0] out_attr_or_cmd;
        logic        out_specific;
        logic [31:0] out_count;
        logic [31:0] out_last_seen_s;
        logic [63:0] out_last_device;
        logic        last_of_run;
    } t_out_rsp;

    typedef struct packed {
        logic [15:0] cluster;
        logic [15:0] attr_id;
        logic        specific;
        logic [31:0] count;
        logic [31:0] last_seen;
        logic [63:0] device;
    } t_entry;

    typedef struct packed {
        logic load;
        logic clear_valid;
        logic idx_clr;
        logic rec_eval;
        logic rec_write;
        logic gather;
        logic pass_init;
        logic srt_eval;
        logic rd_sel_best;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic left_zero;
    } t_sts;

endpackage

### hw/rtl/keyed_event_counter_table_lru_unit.sv
// keyed event counter table, least recently seen replacement
// request channel: i_valid / o_stall with payload i_req; a request is taken
// at a rising edge with i_valid high and o_stall low. o_stall stays high
// while a request is being worked on, so one request is handled at a time.
// result channel: o_valid / i_stall with payload o_rsp; only a dump makes
// results, one per gathered entry, newest first, last_of_run on the final one.
// steps, N = NUM_SLOTS, the slot store read one entry at a time:
//   record: full key scan through the slot memory, then write
//   clear or unknown op: done on acceptance, o_stall stays low
//   dump of k entries: a gather pass over the N slots, then per entry
//   a selection pass over the memory per result, then the result is shown
// while i_stall is high the result register holds and the dump pauses.
// reset clears every valid bit at once; the slot memory needs no clearing
// pass since only valid slots are ever reported.
module keyed_event_counter_table_lru_unit #(
    parameter int NUM_SLOTS = kect_pkg::NumSlotsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  kect_pkg::t_in_req  i_req,
    output logic               o_valid,
    input  logic               i_stall,
    output kect_pkg::t_out_rsp o_rsp
);
    import kect_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    kect_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_req.operation),
        .i_out_stall (i_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_busy      (o_stall),
        .o_out_valid (o_valid)
    );

    kect_dp #(.NumSlots(NUM_SLOTS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp)
    );

endmodule

### hw/rtl/kect_ram.sv
module kect_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/kect_ctrl.sv
module kect_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_op,
    input  logic                i_out_stall,
    input  kect_pkg::t_sts      i_sts,
    output kect_pkg::t_cmd      o_cmd,
    output logic                o_busy,
    output logic                o_out_valid
);
    import kect_pkg::*;

    localparam logic [3:0] StIdle  = 4'd0;
    localparam logic [3:0] StRecRd = 4'd1;
    localparam logic [3:0] StRecEv = 4'd2;
    localparam logic [3:0] StRecWr = 4'd3;
    localparam logic [3:0] StGath  = 4'd4;
    localparam logic [3:0] StPass  = 4'd5;
    localparam logic [3:0] StSrtRd = 4'd6;
    localparam logic [3:0] StSrtEv = 4'd7;
    localparam logic [3:0] StOutRd = 4'd8;
    localparam logic [3:0] StOutLd = 4'd9;
    localparam logic [3:0] StOut   = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            StIdle: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_op)
                        OpRecord: begin
                            o_cmd.idx_clr = 1'b1;
                            n_state = StRecRd;
                        end
                        OpDump: begin
                            o_cmd.idx_clr = 1'b1;
                            n_state = StGath;
                        end
                        OpClear: o_cmd.clear_valid = 1'b1;
                        default: ;
                    endcase
                end
            end
            StRecRd: n_state = StRecEv;
            StRecEv: begin
                o_cmd.rec_eval = 1'b1;
                n_state = i_sts.idx_last ? StRecWr : StRecRd;
            end
            StRecWr: begin
                o_cmd.rec_write = 1'b1;
                n_state = StIdle;
            end
            StGath: begin
                o_cmd.gather = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = StPass;
                end
            end
            StPass: begin
                if (i_sts.left_zero) begin
                    n_state = StIdle;
                end else begin
                    o_cmd.pass_init = 1'b1;
                    n_state = StSrtRd;
                end
            end
            StSrtRd: n_state = StSrtEv;
            StSrtEv: begin
                o_cmd.srt_eval = 1'b1;
                n_state = i_sts.idx_last ? StOutRd : StSrtRd;
            end
            StOutRd: begin
                o_cmd.rd_sel_best = 1'b1;
                n_state = StOutLd;
            end
            StOutLd: begin
                o_cmd.out_load = 1'b1;
                n_state = StOut;
            end
            StOut: begin
                if (!i_out_stall) begin
                    n_state = StPass;
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy      = (r_state != StIdle);
    assign o_out_valid = (r_state == StOut);

    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_busy)
        else $error("result shown while idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("loaded result not shown");

endmodule

### hw/rtl/kect_dp.sv
module kect_dp #(
    parameter int NumSlots = kect_pkg::NumSlotsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kect_pkg::t_in_req  i_req,
    input  kect_pkg::t_cmd     i_cmd,
    output kect_pkg::t_sts     o_sts,
    output kect_pkg::t_out_rsp o_rsp
);
    import kect_pkg::*;

    localparam int IW = $clog2(NumSlots);

    t_in_req         r_req;
    logic [NumSlots-1:0] r_valid;
    logic [NumSlots-1:0] r_sel;
    logic [IW-1:0]   r_idx;
    logic            r_hit;
    logic [IW-1:0]   r_hit_idx;
    logic [31:0]     r_hit_cnt;
    logic            r_free;
    logic [IW-1:0]   r_free_idx;
    logic [31:0]     r_oldest;
    logic [IW-1:0]   r_victim;
    logic [LimW-1:0] r_lim;
    logic [LimW-1:0] r_left;
    logic            r_best_f;
    logic [31:0]     r_best_ts;
    logic [IW-1:0]   r_best;
    t_out_rsp        r_rsp;

    t_entry        w_rd;
    t_entry        w_wd;
    logic [IW-1:0] w_wslot;
    logic [IW-1:0] w_raddr;
    logic          w_key_eq;

    assign w_raddr  = i_cmd.rd_sel_best ? r_best : r_idx;
    assign w_key_eq = (w_rd.cluster == r_req.in_cluster)
        && (w_rd.attr_id == r_req.in_attr_or_cmd)
        && (w_rd.specific == r_req.in_specific);

    always_comb begin
        w_wslot = r_hit ? r_hit_idx : (r_free ? r_free_idx : r_victim);
        w_wd.cluster     = r_req.in_cluster;
        w_wd.attr_id     = r_req.in_attr_or_cmd;
        w_wd.specific    = r_req.in_specific;
        w_wd.last_seen   = r_req.in_time_s;
        w_wd.device      = r_req.in_device_address;
        if (!r_hit) begin
            w_wd.count = 32'd1;
        end else if (r_hit_cnt == CountMax) begin
            w_wd.count = CountMax;
        end else begin
            w_wd.count = r_hit_cnt + 32'd1;
        end
    end

    kect_ram #(.Width($bits(t_entry)), .Depth(NumSlots)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rec_write),
        .i_waddr (w_wslot),
        .i_wdata (w_wd),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.clear_valid) begin
            r_valid <= '0;
        end else if (i_cmd.rec_write) begin
            r_valid[w_wslot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_lim <= (i_req.dump_limit > LimW'(MaxOut)) ? LimW'(MaxOut) : i_req.dump_limit;
        end
        if (i_cmd.idx_clr || i_cmd.pass_init) begin
            r_idx    <= '0;
            r_best_f <= 1'b0;
        end
        if (i_cmd.idx_clr) begin
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_oldest <= CountMax;
            r_victim <= '0;
            r_sel    <= '0;
            r_left   <= '0;
        end
        if (i_cmd.rec_eval) begin
            r_idx <= r_idx + 1'b1;
            if (r_valid[r_idx] && w_key_eq && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
                r_hit_cnt <= w_rd.count;
            end
            if (!r_valid[r_idx] && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (w_rd.last_seen < r_oldest) begin
                r_oldest <= w_rd.last_seen;
                r_victim <= r_idx;
            end
        end
        if (i_cmd.gather) begin
            r_idx <= r_idx + 1'b1;
            if (r_valid[r_idx] && r_left < r_lim) begin
                r_sel[r_idx] <= 1'b1;
                r_left       <= r_left + 1'b1;
            end
        end
        // newest first, strict compare keeps the lower index on ties
        if (i_cmd.srt_eval) begin
            r_idx <= r_idx + 1'b1;
            if (r_sel[r_idx] && (!r_best_f || w_rd.last_seen > r_best_ts)) begin
                r_best_f  <= 1'b1;
                r_best_ts <= w_rd.last_seen;
                r_best    <= r_idx;
            end
        end
        if (i_cmd.out_load) begin
            r_sel[r_best]         <= 1'b0;
            r_left                <= r_left - 1'b1;
            r_rsp.out_cluster     <= w_rd.cluster;
            r_rsp.out_attr_or_cmd <= w_rd.attr_id;
            r_rsp.out_specific    <= w_rd.specific;
            r_rsp.out_count       <= w_rd.count;
            r_rsp.out_last_seen_s <= w_rd.last_seen;
            r_rsp.out_last_device <= w_rd.device;
            r_rsp.last_of_run     <= (r_left == LimW'(1));
        end
    end

    assign o_sts.idx_last  = (r_idx == IW'(NumSlots - 1));
    assign o_sts.left_zero = (r_left == '0);
    assign o_rsp           = r_rsp;

    a_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> r_left != '0)
        else $error("emit with nothing gathered");
    a_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gather |-> r_left <= r_lim)
        else $error("gather past limit");
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rec_write |=> r_valid[$past(w_wslot)])
        else $error("written slot not valid");

endmodule
